/* hw/rtl/atm_pkg.sv */
// Shared types and constants of the accelerometer tilt and magnitude unit.
package atm_pkg;

  localparam int MagW       = 16;
  localparam int TiltW      = 14;
  localparam int AngW       = 29;
  localparam int CordW      = 36;
  localparam int CordSteps  = 24;
  localparam int HRootSteps = 32;
  localparam int MagSteps   = 16;
  localparam int RecipShift = 40;
  localparam int RoundW     = 27;

  typedef logic signed [AngW-1:0] ang_t;

  // atan(2^-i) in units of 1e-6 degree.
  localparam ang_t AtanTab [CordSteps] = '{
    29'sd45000000, 29'sd26565051, 29'sd14036243, 29'sd7125016, 29'sd3576334,
    29'sd1789911, 29'sd895174, 29'sd447614, 29'sd223811, 29'sd111906,
    29'sd55953, 29'sd27976, 29'sd13988, 29'sd6994, 29'sd3497, 29'sd1749,
    29'sd874, 29'sd437, 29'sd219, 29'sd109, 29'sd55, 29'sd27, 29'sd14, 29'sd7
  };

  localparam logic [RoundW-1:0] RecipMul  = 27'd109951163;
  localparam logic [RoundW-1:0] RoundBias = 27'd5000;
  localparam ang_t              AngMax    = 29'sd90000000;
  localparam logic [TiltW-1:0]  TiltMax   = 14'd9000;
  localparam logic [15:0]       ThreshReset = 16'd8197;

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic [32:0]     az_x;
    logic [31:0]     hroot;
    logic            zero;
  } root_res_t;

  typedef struct packed {
    ang_t            ang;
    logic [MagW-1:0] mag;
    logic            zero;
  } cord_res_t;

endpackage

/* hw/rtl/atm_root.sv */
// Squares, sums and the two pipelined integer square roots.
module atm_root (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  output logic               out_valid,
  output atm_pkg::root_res_t out
);
  import atm_pkg::*;

  logic [31:0] sqx, sqy, sqz;
  logic [15:0] az_abs0, az_abs1;
  logic        vld_sq;

  logic [63:0] hv [HRootSteps+1];
  logic [63:0] hr [HRootSteps+1];
  logic [31:0] mv [HRootSteps+1];
  logic [31:0] mr [HRootSteps+1];
  logic [15:0] azp [HRootSteps+1];
  logic        zp [HRootSteps+1];
  logic        vld [HRootSteps+1];

  logic [31:0] hsq, ssum;
  logic [16:0] mag_r;

  // Stage 1: squares.
  always_ff @(posedge clk) begin
    if (en) begin
      sqx     <= 32'(ax * ax);
      sqy     <= 32'(ay * ay);
      sqz     <= 32'(az * az);
      az_abs0 <= az[15] ? 16'(-az) : az;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sq <= 1'b0;
    end else if (en) begin
      vld_sq <= in_valid;
    end
  end

  assign hsq  = sqx + sqy;
  assign ssum = hsq + sqz;
  assign az_abs1 = az_abs0;

  // Stage 2: sums.
  always_ff @(posedge clk) begin
    if (en) begin
      hv[0]  <= {hsq, 32'd0};
      hr[0]  <= 64'd0;
      mv[0]  <= ssum;
      mr[0]  <= 32'd0;
      azp[0] <= az_abs1;
      zp[0]  <= (ssum == 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_sq;
    end
  end

  // One bit per stage; magnitude only while k < MagSteps.
  for (genvar k = 0; k < HRootSteps; k++) begin : g_stage
    localparam logic [63:0] HBit = 64'd1 << (62 - 2 * k);
    logic [63:0] hsum, hv_next, hr_next;
    logic [31:0] msum, mv_next, mr_next;

    assign hsum = hr[k] + HBit;
    always_comb begin
      if (hv[k] >= hsum) begin
        hv_next = hv[k] - hsum;
        hr_next = (hr[k] >> 1) + HBit;
      end else begin
        hv_next = hv[k];
        hr_next = hr[k] >> 1;
      end
    end

    if (k < MagSteps) begin : g_mag
      localparam logic [31:0] MBit = 32'd1 << (30 - 2 * k);
      assign msum = mr[k] + MBit;
      always_comb begin
        if (mv[k] >= msum) begin
          mv_next = mv[k] - msum;
          mr_next = (mr[k] >> 1) + MBit;
        end else begin
          mv_next = mv[k];
          mr_next = mr[k] >> 1;
        end
      end
    end else begin : g_hold
      assign msum    = mr[k];
      assign mv_next = mv[k];
      assign mr_next = msum;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hv[k+1]  <= hv_next;
        hr[k+1]  <= hr_next;
        mv[k+1]  <= mv_next;
        mr[k+1]  <= mr_next;
        azp[k+1] <= azp[k];
        zp[k+1]  <= zp[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // Round to nearest: the remainder exceeds the root.
  assign mag_r = 17'(mr[HRootSteps]) + {16'd0, (mv[HRootSteps] > mr[HRootSteps])};

  assign out_valid = vld[HRootSteps];
  assign out.mag   = mag_r[MagW-1:0];
  assign out.az_x  = {1'b0, azp[HRootSteps], 16'd0};
  assign out.hroot = hr[HRootSteps][31:0];
  assign out.zero  = zp[HRootSteps];

endmodule

/* hw/rtl/atm_cordic.sv */
// Pipelined CORDIC vectoring, one rotation per stage.
module atm_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  atm_pkg::root_res_t in,
  output logic               out_valid,
  output atm_pkg::cord_res_t out
);
  import atm_pkg::*;

  logic signed [CordW-1:0] x [CordSteps+1];
  logic signed [CordW-1:0] y [CordSteps+1];
  ang_t                    a [CordSteps+1];
  logic [MagW-1:0]         mg [CordSteps+1];
  logic                    zr [CordSteps+1];
  logic                    vld [CordSteps+1];

  assign x[0]   = CordW'(in.az_x);
  assign y[0]   = CordW'(in.hroot);
  assign a[0]   = '0;
  assign mg[0]  = in.mag;
  assign zr[0]  = in.zero;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < CordSteps; i++) begin : g_rot
    logic signed [CordW-1:0] dx, dy, ny, nx;

    // Shifts round toward zero.
    assign ny = -y[i];
    assign nx = -x[i];
    assign dx = y[i][CordW-1] ? -(ny >>> i) : (y[i] >>> i);
    assign dy = x[i][CordW-1] ? -(nx >>> i) : (x[i] >>> i);

    always_ff @(posedge clk) begin
      if (en) begin
        if (y[i] > 0) begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          a[i+1] <= a[i] + AtanTab[i];
        end else begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          a[i+1] <= a[i] - AtanTab[i];
        end
        mg[i+1] <= mg[i];
        zr[i+1] <= zr[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_valid = vld[CordSteps];
  assign out.ang   = a[CordSteps];
  assign out.mag   = mg[CordSteps];
  assign out.zero  = zr[CordSteps];

endmodule

/* hw/rtl/atm_round.sv */
// Angle clamp and rounding to centidegrees, freefall decision, output register.
module atm_round (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  atm_pkg::cord_res_t          in,
  input  logic [15:0]                 threshold,
  output logic                        out_valid,
  output logic [atm_pkg::MagW-1:0]    mag,
  output logic [atm_pkg::TiltW-1:0]   tilt,
  output logic                        ff
);
  import atm_pkg::*;

  ang_t                  ang_c;
  logic [RoundW-1:0]     biased;
  logic [2*RoundW-1:0]   prod;
  logic [MagW-1:0]       mag_a;
  logic                  ff_a, zero_a, vld_a;
  logic [TiltW-1:0]      q;

  always_comb begin
    if (in.ang < 0) begin
      ang_c = '0;
    end else if (in.ang > AngMax) begin
      ang_c = AngMax;
    end else begin
      ang_c = in.ang;
    end
  end

  assign biased = RoundW'(ang_c) + RoundBias;

  // Division by 10000 as a multiply by the reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= biased * RecipMul;
      mag_a  <= in.mag;
      ff_a   <= (in.mag < threshold);
      zero_a <= in.zero;
    end
  end

  assign q = prod[RecipShift+TiltW-1:RecipShift];

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= mag_a;
      ff  <= ff_a;
      if (ff_a || zero_a) begin
        tilt <= '0;
      end else if (q > TiltMax) begin
        tilt <= TiltMax;
      end else begin
        tilt <= q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_valid;
      out_valid <= vld_a;
    end
  end

endmodule

/* hw/rtl/accel_tilt_and_magnitude_unit.sv */
// Throughput: one sample per cycle; the whole pipeline advances together and holds
// while the output register is full and not taken, so a stall loses nothing.
// The longest part is the 32-stage root of the horizontal norm, then 24 CORDIC stages.
// Reset (synchronous, active high) clears all valid bits and sets the threshold to 8197.
module accel_tilt_and_magnitude_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // magnitude[15:0], tilt_centideg[29:16]
  output logic        m_axis_tuser,  // freefall[0]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import atm_pkg::*;

  logic               en;
  logic [15:0]        threshold;
  logic               root_valid, cord_valid;
  root_res_t          root_res;
  cord_res_t          cord_res;
  logic [MagW-1:0]    mag;
  logic [TiltW-1:0]   tilt;
  logic               ff;

  // Every stage moves when the output register is empty or being drained.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Freefall threshold register; the user writes it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThreshReset;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // Squares, sums, magnitude root and horizontal root.
  atm_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .ax        (s_axis_tdata[15:0]),
    .ay        (s_axis_tdata[31:16]),
    .az        (s_axis_tdata[47:32]),
    .out_valid (root_valid),
    .out       (root_res)
  );

  // Angle of the horizontal norm against |az|.
  atm_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .in        (root_res),
    .out_valid (cord_valid),
    .out       (cord_res)
  );

  // Rounding, freefall decision and the output register.
  atm_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cord_valid),
    .in        (cord_res),
    .threshold (threshold),
    .out_valid (m_axis_tvalid),
    .mag       (mag),
    .tilt      (tilt),
    .ff        (ff)
  );

  // The freefall flag says the tilt is not meaningful, so it travels beside the data.
  assign m_axis_tdata = {2'b00, tilt, mag};
  assign m_axis_tuser = ff;

endmodule
